[rtl/ecp_pkg.sv]
// ----------------------------------------------------------------------------
// ecp_pkg
// Shared types, register indexes, mode codes and widths for the escape count
// palette.
// ----------------------------------------------------------------------------
`default_nettype none

package ecp_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int SMOOTH_W       = 32;
  localparam int CHAN_W         = 8;
  localparam int LIMIT_W        = 24;
  localparam int BAND_W         = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 24;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_BANDED = 2'd1;
  localparam logic [1:0] MODE_HSV    = 2'd2;
  localparam logic [1:0] MODE_OFF    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd256;
  localparam logic [BAND_W-1:0]  BAND_RESET  = 16'd150;

  // Context that travels with every item down the pipeline.
  typedef struct packed {
    logic [1:0]          mode;
    logic                black;
    logic [SMOOTH_W-1:0] smooth;
  } ecp_ctx_t;

  function automatic int max2(int a, int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

[rtl/ecp_div_pipe.sv]
// ----------------------------------------------------------------------------
// ecp_div_pipe
// Restoring divider, one quotient bit per register stage, with a side band
// that travels alongside each item.
// ----------------------------------------------------------------------------
`default_nettype none

module ecp_div_pipe
  import ecp_pkg::*;
#(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 16,
  parameter int QUO_W  = 8,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [QUO_W-1:0]  out_quo,
  output logic [DEN_W-1:0]  out_rem,
  output logic [SIDE_W-1:0] out_side
);

  localparam int CW = max2(NUM_W, DEN_W + QUO_W);

  logic [CW-1:0]     rem_r  [QUO_W];
  logic [QUO_W-1:0]  quo_r  [QUO_W];
  logic [DEN_W-1:0]  den_r  [QUO_W];
  logic [SIDE_W-1:0] side_r [QUO_W];
  logic              vld_r  [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [CW-1:0]     rem_in;
    logic [CW-1:0]     trial;
    logic [CW-1:0]     rem_nxt;
    logic [QUO_W-1:0]  quo_in;
    logic [QUO_W-1:0]  quo_nxt;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;

    if (i == 0) begin : g_head
      assign rem_in  = CW'(in_num);
      assign quo_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_body
      assign rem_in  = rem_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign den_in  = den_r[i-1];
      assign side_in = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    always_comb begin
      trial   = CW'(den_in) << (QUO_W - 1 - i);
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      if (rem_in >= trial) begin
        rem_nxt                = rem_in - trial;
        quo_nxt[QUO_W - 1 - i] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      rem_r[i]  <= rem_nxt;
      quo_r[i]  <= quo_nxt;
      den_r[i]  <= den_in;
      side_r[i] <= side_in;
    end
  end

  assign out_vld  = vld_r[QUO_W-1];
  assign out_quo  = quo_r[QUO_W-1];
  assign out_rem  = rem_r[QUO_W-1][DEN_W-1:0];
  assign out_side = side_r[QUO_W-1];

endmodule

`default_nettype wire

[rtl/ecp_isqrt_pipe.sv]
// ----------------------------------------------------------------------------
// ecp_isqrt_pipe
// Integer square root, one root bit per register stage, with a side band
// that travels alongside each item.
// ----------------------------------------------------------------------------
`default_nettype none

module ecp_isqrt_pipe
  import ecp_pkg::*;
#(
  parameter int IN_W   = 24,
  parameter int SIDE_W = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic [IN_W-1:0]         in_val,
  input  logic [SIDE_W-1:0]       in_side,
  output logic                    out_vld,
  output logic [(IN_W+1)/2-1:0]   out_root,
  output logic [SIDE_W-1:0]       out_side
);

  localparam int RW = (IN_W + 1) / 2;
  localparam int CW = IN_W + 1;

  logic [CW-1:0]     rem_r  [RW];
  logic [RW-1:0]     root_r [RW];
  logic [SIDE_W-1:0] side_r [RW];
  logic              vld_r  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [CW-1:0]     rem_in;
    logic [CW-1:0]     trial;
    logic [CW-1:0]     rem_nxt;
    logic [RW-1:0]     root_in;
    logic [RW-1:0]     root_nxt;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;

    if (i == 0) begin : g_head
      assign rem_in  = CW'(in_val);
      assign root_in = '0;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_body
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign side_in = side_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    // The remainder holds value minus root squared; the trial is the growth
    // of that square when the next root bit is set.
    always_comb begin
      trial    = (CW'(root_in) << (RW - i)) + (CW'(1) << (2 * (RW - 1 - i)));
      rem_nxt  = rem_in;
      root_nxt = root_in;
      if (rem_in >= trial) begin
        rem_nxt             = rem_in - trial;
        root_nxt[RW - 1 - i] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
      rem_r[i]  <= rem_nxt;
      root_r[i] <= root_nxt;
      side_r[i] <= side_in;
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_side = side_r[RW-1];

endmodule

`default_nettype wire

[rtl/escape_count_palette.sv]
// Pipeline: the long division of the smooth count and the square root chain make up
// most of its register stages.
// Throughput: one item per cycle; busy stays low.
// Reset: rst_n empties the pipeline and sets mode 0, limit 256 and band width 150.
// Results are strobed on out_valid for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
// escape_count_palette
// Colours one escape-time pixel from its escape count and smoothed count in
// linear gray, banded gray or HSV hue ramp mode, or black in the off mode.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_count_palette
  import ecp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COUNT_BITS-1:0] in_escape_count,
  input  logic [SMOOTH_W-1:0]   in_smooth_count,
  output logic                  out_valid,
  output logic [CHAN_W-1:0]     out_red,
  output logic [CHAN_W-1:0]     out_green,
  output logic [CHAN_W-1:0]     out_blue,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CTX_W  = $bits(ecp_ctx_t);
  localparam int UW     = SMOOTH_W - FRAC_BITS;
  localparam int DW1    = max2(COUNT_BITS, BAND_W);
  localparam int SW     = (UW + 1) / 2;
  localparam int DW     = COUNT_BITS + FRAC_BITS;
  localparam int BW     = DW1 + FRAC_BITS;
  localparam int SQW    = 2 * SW;
  localparam int BASEW  = SQW + BAND_W;
  localparam int DBW    = SW + 1 + BAND_W;
  localparam int DIFW   = max2(SMOOTH_W, BASEW + FRAC_BITS);
  localparam int NUM2_W = max2(SMOOTH_W + 8, BW + 9);
  localparam int DEN2_W = max2(DW, DBW + FRAC_BITS);
  localparam int SATW   = max2(SMOOTH_W + 8, DW + 8);
  localparam int LOWW   = max2(SMOOTH_W + 4, DW);
  localparam int HUE_W  = 9;
  localparam int K_W    = 6;
  localparam int SEC_W  = 3;
  localparam int N25_W  = SMOOTH_W + 12;
  localparam int NX_W   = N25_W + K_W;
  localparam int DX_W   = DW + 6;

  localparam logic [SEC_W-1:0] SEC_RED     = 3'd0;
  localparam logic [SEC_W-1:0] SEC_YELLOW  = 3'd1;
  localparam logic [SEC_W-1:0] SEC_GREEN   = 3'd2;
  localparam logic [SEC_W-1:0] SEC_CYAN    = 3'd3;
  localparam logic [SEC_W-1:0] SEC_BLUE    = 3'd4;
  localparam logic [SEC_W-1:0] SEC_MAGENTA = 3'd5;

  // Configuration registers
  logic [1:0]         mode_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [BAND_W-1:0]  band_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_LINEAR;
      limit_r <= LIMIT_RESET;
      band_r  <= BAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLOR_MODE: mode_r  <= cfg_data[1:0];
        REG_ITER_LIMIT: limit_r <= cfg_data[LIMIT_W-1:0];
        REG_BAND_WIDTH: band_r  <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // The user must change the configuration only with the pipeline empty; the block
  // itself does not enforce it. Several stages read the limit and band width directly.
  logic [SMOOTH_W-1:0]   limit_ext;
  logic [COUNT_BITS-1:0] lim;
  logic [BAND_W-1:0]     wid;
  logic [DW-1:0]         den_full;

  assign limit_ext = SMOOTH_W'(limit_r);
  assign lim       = (limit_ext[COUNT_BITS-1:0] == '0) ? COUNT_BITS'(1)
                                                       : limit_ext[COUNT_BITS-1:0];
  assign wid       = (band_r == '0) ? BAND_W'(1) : band_r;
  assign den_full  = {lim, {FRAC_BITS{1'b0}}};

  // Entry: the integer part of the smooth count is divided by the band width
  // (banded mode, quotient used) or else by the limit (hue mode, remainder used).
  ecp_ctx_t       ctx_in;
  logic [DW1-1:0] den1;

  always_comb begin
    ctx_in.mode   = mode_r;
    ctx_in.black  = (in_escape_count > lim) || (mode_r == MODE_OFF);
    ctx_in.smooth = in_smooth_count;
    den1          = (mode_r == MODE_BANDED) ? DW1'(wid) : DW1'(lim);
  end

  logic           d1_vld;
  logic [UW-1:0]  d1_quo;
  logic [DW1-1:0] d1_rem;
  logic [CTX_W-1:0] d1_side;

  ecp_div_pipe #(
    .NUM_W (UW),
    .DEN_W (DW1),
    .QUO_W (UW),
    .SIDE_W(CTX_W)
  ) u_div_int (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .in_num  (in_smooth_count[SMOOTH_W-1:FRAC_BITS]),
    .in_den  (den1),
    .in_side (ctx_in),
    .out_vld (d1_vld),
    .out_quo (d1_quo),
    .out_rem (d1_rem),
    .out_side(d1_side)
  );

  logic                 sq_vld;
  logic [SW-1:0]        sq_root;
  logic [DW1+CTX_W-1:0] sq_side;
  logic [DW1-1:0]       sq_rem;
  ecp_ctx_t             sq_ctx;

  ecp_isqrt_pipe #(
    .IN_W  (UW),
    .SIDE_W(DW1 + CTX_W)
  ) u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (d1_vld),
    .in_val  (d1_quo),
    .in_side ({d1_rem, d1_side}),
    .out_vld (sq_vld),
    .out_root(sq_root),
    .out_side(sq_side)
  );

  assign {sq_rem, sq_ctx} = sq_side;

  // Operand preparation, first stage: band square and odd width factor.
  logic           p1_vld_r;
  logic [SQW-1:0] p1_sq_r;
  logic [SW:0]    p1_odd_r;
  logic [BW-1:0]  p1_b_r;
  ecp_ctx_t       p1_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= sq_vld;
    end
    p1_sq_r  <= SQW'(sq_root) * SQW'(sq_root);
    p1_odd_r <= {sq_root, 1'b1};
    p1_b_r   <= {sq_rem, sq_ctx.smooth[FRAC_BITS-1:0]};
    p1_ctx_r <= sq_ctx;
  end

  // Second stage: scale by the band width.
  logic             p2_vld_r;
  logic [BASEW-1:0] p2_base_r;
  logic [DBW-1:0]   p2_dband_r;
  logic [BW-1:0]    p2_b_r;
  logic             p2_sodd_r;
  ecp_ctx_t         p2_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else begin
      p2_vld_r <= p1_vld_r;
    end
    p2_base_r  <= BASEW'(p1_sq_r) * BASEW'(wid);
    p2_dband_r <= DBW'(p1_odd_r) * DBW'(wid);
    p2_b_r     <= p1_b_r;
    p2_sodd_r  <= p1_odd_r[1];
    p2_ctx_r   <= p1_ctx_r;
  end

  // Third stage: pick the dividend and divisor for the mode.
  logic [DIFW-1:0]     diff_w;
  logic [SMOOTH_W-1:0] diff;
  logic [NUM2_W-1:0]   num2;
  logic [DEN2_W-1:0]   den2;
  logic                sat;
  logic                low;

  always_comb begin
    diff_w = DIFW'(p2_ctx_r.smooth) - DIFW'({p2_base_r, {FRAC_BITS{1'b0}}});
    diff   = diff_w[SMOOTH_W-1:0];
    case (p2_ctx_r.mode)
      MODE_LINEAR: begin
        num2 = NUM2_W'(p2_ctx_r.smooth) * NUM2_W'(255);
        den2 = DEN2_W'(den_full);
      end
      MODE_BANDED: begin
        num2 = NUM2_W'(diff) * NUM2_W'(255);
        den2 = DEN2_W'({p2_dband_r, {FRAC_BITS{1'b0}}});
      end
      default: begin
        num2 = NUM2_W'(p2_b_r) * NUM2_W'(360);
        den2 = DEN2_W'(den_full);
      end
    endcase
    sat = (SATW'(p2_ctx_r.smooth) * SATW'(255)) >= SATW'({den_full, 8'd0});
    low = (LOWW'(p2_ctx_r.smooth) * LOWW'(10)) < LOWW'(den_full);
  end

  logic              p3_vld_r;
  logic [NUM2_W-1:0] p3_num_r;
  logic [DEN2_W-1:0] p3_den_r;
  logic              p3_sat_r;
  logic              p3_low_r;
  logic              p3_sodd_r;
  ecp_ctx_t          p3_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else begin
      p3_vld_r <= p2_vld_r;
    end
    p3_num_r  <= num2;
    p3_den_r  <= den2;
    p3_sat_r  <= sat;
    p3_low_r  <= low;
    p3_sodd_r <= p2_sodd_r;
    p3_ctx_r  <= p2_ctx_r;
  end

  // Gray level for both gray modes, or the hue for the HSV mode.
  logic             d2_vld;
  logic [HUE_W-1:0] d2_quo;
  logic [CTX_W+2:0] d2_side;
  logic             d2_sat;
  logic             d2_low;
  logic             d2_sodd;
  ecp_ctx_t         d2_ctx;

  ecp_div_pipe #(
    .NUM_W (NUM2_W),
    .DEN_W (DEN2_W),
    .QUO_W (HUE_W),
    .SIDE_W(CTX_W + 3)
  ) u_div_level (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (p3_vld_r),
    .in_num  (p3_num_r),
    .in_den  (p3_den_r),
    .in_side ({p3_sat_r, p3_low_r, p3_sodd_r, p3_ctx_r}),
    .out_vld (d2_vld),
    .out_quo (d2_quo),
    .out_rem (),
    .out_side(d2_side)
  );

  assign {d2_sat, d2_low, d2_sodd, d2_ctx} = d2_side;

  // Hue decode: sector, distance to the nearest primary and full-value X.
  logic [6:0]        hue_rem;
  logic [K_W-1:0]    k;
  logic [SEC_W-1:0]  sec;
  logic [CHAN_W-1:0] gray;
  logic [10:0]       k17;

  always_comb begin
    if (d2_quo >= 9'd240) begin
      hue_rem = 7'(d2_quo - 9'd240);
    end else if (d2_quo >= 9'd120) begin
      hue_rem = 7'(d2_quo - 9'd120);
    end else begin
      hue_rem = d2_quo[6:0];
    end
    k = (hue_rem >= 7'd60) ? K_W'(7'd120 - hue_rem) : K_W'(hue_rem);

    if (d2_quo < 9'd60) begin
      sec = SEC_RED;
    end else if (d2_quo < 9'd120) begin
      sec = SEC_YELLOW;
    end else if (d2_quo < 9'd180) begin
      sec = SEC_GREEN;
    end else if (d2_quo < 9'd240) begin
      sec = SEC_CYAN;
    end else if (d2_quo < 9'd300) begin
      sec = SEC_BLUE;
    end else begin
      sec = SEC_MAGENTA;
    end

    case (d2_ctx.mode)
      MODE_LINEAR: gray = d2_sat ? 8'hFF : d2_quo[CHAN_W-1:0];
      MODE_BANDED: gray = d2_sodd ? ~d2_quo[CHAN_W-1:0] : d2_quo[CHAN_W-1:0];
      default:     gray = '0;
    endcase

    // 255/60 is exactly 17/4.
    k17 = 11'(k) * 11'(17);
  end

  logic              h1_vld_r;
  logic [CHAN_W-1:0] h1_gray_r;
  logic [SEC_W-1:0]  h1_sec_r;
  logic [K_W-1:0]    h1_k_r;
  logic [CHAN_W-1:0] h1_xhi_r;
  logic [N25_W-1:0]  h1_n25_r;
  logic              h1_low_r;
  ecp_ctx_t          h1_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_vld_r <= 1'b0;
    end else begin
      h1_vld_r <= d2_vld;
    end
    h1_gray_r <= gray;
    h1_sec_r  <= sec;
    h1_k_r    <= k;
    h1_xhi_r  <= k17[CHAN_W+1:2];
    h1_n25_r  <= N25_W'(d2_ctx.smooth) * N25_W'(2550);
    h1_low_r  <= d2_low;
    h1_ctx_r  <= d2_ctx;
  end

  logic              h2_vld_r;
  logic [NX_W-1:0]   h2_nx_r;
  logic [N25_W-1:0]  h2_n25_r;
  logic [CHAN_W-1:0] h2_gray_r;
  logic [SEC_W-1:0]  h2_sec_r;
  logic [CHAN_W-1:0] h2_xhi_r;
  logic              h2_low_r;
  ecp_ctx_t          h2_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h2_vld_r <= 1'b0;
    end else begin
      h2_vld_r <= h1_vld_r;
    end
    h2_nx_r   <= NX_W'(h1_n25_r) * NX_W'(h1_k_r);
    h2_n25_r  <= h1_n25_r;
    h2_gray_r <= h1_gray_r;
    h2_sec_r  <= h1_sec_r;
    h2_xhi_r  <= h1_xhi_r;
    h2_low_r  <= h1_low_r;
    h2_ctx_r  <= h1_ctx_r;
  end

  // Low-value chroma and secondary component, both only needed when the
  // value ramp has not yet reached full scale.
  logic                    dx_vld;
  logic [CHAN_W-1:0]       dx_quo;
  logic [2*CHAN_W+CTX_W:0] dx_side;
  logic [CHAN_W-1:0]       dx_gray;
  logic [CHAN_W-1:0]       dx_xhi;
  logic                    dx_low;
  ecp_ctx_t                dx_ctx;
  logic                    dc_vld;
  logic [CHAN_W-1:0]       dc_quo;
  logic [SEC_W-1:0]        dc_sec;
  logic [DX_W-1:0]         den_x;

  assign den_x = DX_W'(den_full) * DX_W'(60);

  ecp_div_pipe #(
    .NUM_W (NX_W),
    .DEN_W (DX_W),
    .QUO_W (CHAN_W),
    .SIDE_W(2 * CHAN_W + 1 + CTX_W)
  ) u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (h2_vld_r),
    .in_num  (h2_nx_r),
    .in_den  (den_x),
    .in_side ({h2_gray_r, h2_xhi_r, h2_low_r, h2_ctx_r}),
    .out_vld (dx_vld),
    .out_quo (dx_quo),
    .out_rem (),
    .out_side(dx_side)
  );

  assign {dx_gray, dx_xhi, dx_low, dx_ctx} = dx_side;

  ecp_div_pipe #(
    .NUM_W (N25_W),
    .DEN_W (DW),
    .QUO_W (CHAN_W),
    .SIDE_W(SEC_W)
  ) u_div_c (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (h2_vld_r),
    .in_num  (h2_n25_r),
    .in_den  (den_full),
    .in_side (h2_sec_r),
    .out_vld (dc_vld),
    .out_quo (dc_quo),
    .out_rem (),
    .out_side(dc_sec)
  );

  // Output colour.
  logic [CHAN_W-1:0] cval;
  logic [CHAN_W-1:0] xval;
  logic [CHAN_W-1:0] red_nxt;
  logic [CHAN_W-1:0] green_nxt;
  logic [CHAN_W-1:0] blue_nxt;

  always_comb begin
    cval = dx_low ? dc_quo : 8'hFF;
    xval = dx_low ? dx_quo : dx_xhi;
    case (dc_sec)
      SEC_RED:    begin red_nxt = cval; green_nxt = xval; blue_nxt = '0;   end
      SEC_YELLOW: begin red_nxt = xval; green_nxt = cval; blue_nxt = '0;   end
      SEC_GREEN:  begin red_nxt = '0;   green_nxt = cval; blue_nxt = xval; end
      SEC_CYAN:   begin red_nxt = '0;   green_nxt = xval; blue_nxt = cval; end
      SEC_BLUE:   begin red_nxt = xval; green_nxt = '0;   blue_nxt = cval; end
      default:    begin red_nxt = cval; green_nxt = '0;   blue_nxt = xval; end
    endcase
    if (dx_ctx.black) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end else if (dx_ctx.mode != MODE_HSV) begin
      red_nxt   = dx_gray;
      green_nxt = dx_gray;
      blue_nxt  = dx_gray;
    end
  end

  logic              out_valid_r;
  logic [CHAN_W-1:0] out_red_r;
  logic [CHAN_W-1:0] out_green_r;
  logic [CHAN_W-1:0] out_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dx_vld && dc_vld;
    end
    out_red_r   <= red_nxt;
    out_green_r <= green_nxt;
    out_blue_r  <= blue_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

`default_nettype wire
